// ----- sv/udst_pkg.sv -----
// Shared types and constants for the UDP socket demux table.
// Used by udst_front, udst_back and udp_socket_demux_table; depends on nothing.
package udst_pkg;

  localparam int MAX_SESSIONS_DEF = 16;
  localparam int SLOT_W           = 4;
  localparam int IP_W             = 32;
  localparam int PORT_W           = 16;
  localparam int SOCK_W           = 16;
  localparam int REQ_W            = 2;
  localparam int STATUS_W         = 3;
  localparam int QUEUE_DEPTH      = 2;

  // Request codes on in_req_type
  localparam logic [REQ_W-1:0] REQ_DELIVER = 2'd0;
  localparam logic [REQ_W-1:0] REQ_OPEN    = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CLOSE   = 2'd2;

  typedef enum logic [STATUS_W-1:0] {
    ST_CONNECTED = 3'd0,
    ST_WILDCARD  = 3'd1,
    ST_NOMATCH   = 3'd2,
    ST_OPENED    = 3'd3,
    ST_CLOSED    = 3'd4
  } status_t;

  // Classified operation handed from the front to the back
  typedef enum logic [1:0] {
    OP_DGRAM,
    OP_OPEN,
    OP_CLOSE,
    OP_REJECT
  } op_t;

  typedef struct packed {
    op_t                op;
    logic [SLOT_W-1:0]  slot;
    logic [IP_W-1:0]    peer_ip;
    logic [PORT_W-1:0]  peer_port;
    logic [PORT_W-1:0]  own_port;
    logic               own_is_any;
    logic [SOCK_W-1:0]  socket_id;
  } cmd_t;

  // One session as stored in the table RAM
  typedef struct packed {
    logic               local_any;
    logic [PORT_W-1:0]  local_port;
    logic [IP_W-1:0]    remote_ip;
    logic [PORT_W-1:0]  remote_port;
    logic [SOCK_W-1:0]  socket;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

// ----- sv/udst_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module udst_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- sv/udst_front.sv -----
// Front end of the demux table: accepts requests, classifies them and queues them.
// Depends on udst_pkg.
module udst_front #(
  parameter int MAX_SESSIONS = udst_pkg::MAX_SESSIONS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         start,
  output logic                         busy,
  input  logic [udst_pkg::REQ_W-1:0]   in_req_type,
  input  logic [udst_pkg::SLOT_W-1:0]  in_slot,
  input  logic [udst_pkg::IP_W-1:0]    in_peer_ip,
  input  logic [udst_pkg::PORT_W-1:0]  in_peer_port,
  input  logic [udst_pkg::PORT_W-1:0]  in_own_port,
  input  logic                         in_own_is_any,
  input  logic [udst_pkg::SOCK_W-1:0]  in_socket_id,
  output logic                         head_valid,
  output udst_pkg::cmd_t               head,
  input  logic                         pop
);

  localparam int QD   = udst_pkg::QUEUE_DEPTH;
  localparam int QAW  = $clog2(QD);
  localparam int QCW  = $clog2(QD + 1);

  udst_pkg::cmd_t  q_r [QD];
  logic [QAW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]  cnt_r, cnt_nxt;
  udst_pkg::cmd_t  cmd;
  logic            in_range;
  logic            push;
  logic            do_pop;

  // Classify: an open or close on a slot past the table, and unknown codes, become a reject
  always_comb begin
    in_range    = ({{(32 - udst_pkg::SLOT_W){1'b0}}, in_slot} < 32'(MAX_SESSIONS));
    cmd.slot       = in_slot;
    cmd.peer_ip    = in_peer_ip;
    cmd.peer_port  = in_peer_port;
    cmd.own_port   = in_own_port;
    cmd.own_is_any = in_own_is_any;
    cmd.socket_id  = in_socket_id;
    case (in_req_type)
      udst_pkg::REQ_DELIVER: cmd.op = udst_pkg::OP_DGRAM;
      udst_pkg::REQ_OPEN:    cmd.op = in_range ? udst_pkg::OP_OPEN : udst_pkg::OP_REJECT;
      udst_pkg::REQ_CLOSE:   cmd.op = in_range ? udst_pkg::OP_CLOSE : udst_pkg::OP_REJECT;
      default:               cmd.op = udst_pkg::OP_REJECT;
    endcase
  end

  assign busy       = (cnt_r == QCW'(QD));
  assign push       = start && !busy;
  assign head_valid = (cnt_r != '0);
  assign do_pop     = pop && head_valid;
  assign head       = q_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QAW'(QD - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == QAW'(QD - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (!push && do_pop) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
    if (push) begin
      q_r[wr_ptr_r] <= cmd;
    end
  end

endmodule

// ----- sv/udst_back.sv -----
// Back end of the demux table: session RAM, valid bits, datagram scan and result register.
// Depends on udst_pkg and udst_ram.
module udst_back #(
  parameter int MAX_SESSIONS = udst_pkg::MAX_SESSIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          head_valid,
  input  udst_pkg::cmd_t                head,
  output logic                          pop,
  output logic                          out_valid,
  output logic [udst_pkg::STATUS_W-1:0] out_status,
  output logic [udst_pkg::SLOT_W-1:0]   out_hit_slot,
  output logic [udst_pkg::SOCK_W-1:0]   out_hit_socket
);

  // Only slots the slot field can reach are ever opened
  localparam int SLOT_LIM  = 1 << udst_pkg::SLOT_W;
  localparam int TBL_DEPTH = (MAX_SESSIONS < SLOT_LIM) ? MAX_SESSIONS : SLOT_LIM;
  localparam int IDX_W     = $clog2(TBL_DEPTH);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TBL_DEPTH - 1);

  typedef enum logic {S_IDLE, S_SCAN} state_t;

  state_t                        state_r, state_nxt;
  logic [TBL_DEPTH-1:0]          valid_r, valid_nxt;
  udst_pkg::cmd_t                cur_r, cur_nxt;
  logic [IDX_W-1:0]              cmp_idx_r, cmp_idx_nxt;
  logic                          wild_found_r, wild_found_nxt;
  logic [IDX_W-1:0]              wild_idx_r, wild_idx_nxt;
  udst_pkg::entry_t              wild_ent_r, wild_ent_nxt;
  logic                          out_valid_r, out_valid_nxt;
  udst_pkg::status_t             out_status_r, out_status_nxt;
  logic [udst_pkg::SLOT_W-1:0]   out_slot_r, out_slot_nxt;
  logic [udst_pkg::SOCK_W-1:0]   out_sock_r, out_sock_nxt;

  logic                          ram_we;
  logic [IDX_W-1:0]              ram_waddr;
  udst_pkg::entry_t              ram_wdata;
  logic [IDX_W-1:0]              ram_raddr;
  logic [udst_pkg::ENTRY_W-1:0]  ram_rdata;

  udst_pkg::entry_t              ent;
  udst_pkg::entry_t              bind_ent;
  logic [IDX_W-1:0]              head_idx;
  logic [IDX_W-1:0]              bind_idx;
  logic                          ent_v;
  logic                          conn_hit;
  logic                          wild_hit;
  logic                          take_wild;
  logic                          at_last;

  udst_ram #(
    .WIDTH (udst_pkg::ENTRY_W),
    .DEPTH (TBL_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign ent       = udst_pkg::entry_t'(ram_rdata);
  assign head_idx  = head.slot[IDX_W-1:0];
  assign ent_v     = valid_r[cmp_idx_r];
  assign conn_hit  = ent_v && (ent.remote_ip == cur_r.peer_ip) &&
                     (ent.local_port == cur_r.own_port) &&
                     (ent.remote_port == cur_r.peer_port);
  assign wild_hit  = ent_v && ent.local_any && (ent.local_port == cur_r.own_port);
  assign take_wild = wild_hit && !wild_found_r;
  assign at_last   = (cmp_idx_r == LAST_IDX);
  assign bind_idx  = take_wild ? cmp_idx_r : wild_idx_r;

  // Prefetch entry 0 while idle so a scan starts with data in hand
  assign ram_raddr = (state_r == S_SCAN && !at_last) ? cmp_idx_r + 1'b1 : '0;

  always_comb begin
    state_nxt      = state_r;
    valid_nxt      = valid_r;
    cur_nxt        = cur_r;
    cmp_idx_nxt    = cmp_idx_r;
    wild_found_nxt = wild_found_r;
    wild_idx_nxt   = wild_idx_r;
    wild_ent_nxt   = wild_ent_r;
    out_valid_nxt  = 1'b0;
    out_status_nxt = out_status_r;
    out_slot_nxt   = out_slot_r;
    out_sock_nxt   = out_sock_r;
    pop            = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = head_idx;
    ram_wdata.local_any   = head.own_is_any;
    ram_wdata.local_port  = head.own_port;
    ram_wdata.remote_ip   = head.peer_ip;
    ram_wdata.remote_port = head.peer_port;
    ram_wdata.socket      = head.socket_id;
    bind_ent       = take_wild ? ent : wild_ent_r;

    case (state_r)
      S_IDLE: begin
        if (head_valid) begin
          pop = 1'b1;
          case (head.op)
            udst_pkg::OP_OPEN: begin
              ram_we              = 1'b1;
              valid_nxt[head_idx] = 1'b1;
              out_valid_nxt       = 1'b1;
              out_status_nxt      = udst_pkg::ST_OPENED;
              out_slot_nxt        = head.slot;
              out_sock_nxt        = '0;
            end
            udst_pkg::OP_CLOSE: begin
              valid_nxt[head_idx] = 1'b0;
              out_valid_nxt       = 1'b1;
              out_status_nxt      = udst_pkg::ST_CLOSED;
              out_slot_nxt        = head.slot;
              out_sock_nxt        = '0;
            end
            udst_pkg::OP_DGRAM: begin
              cur_nxt        = head;
              cmp_idx_nxt    = '0;
              wild_found_nxt = 1'b0;
              state_nxt      = S_SCAN;
            end
            default: begin
              out_valid_nxt  = 1'b1;
              out_status_nxt = udst_pkg::ST_NOMATCH;
              out_slot_nxt   = '0;
              out_sock_nxt   = '0;
            end
          endcase
        end
      end

      S_SCAN: begin
        if (conn_hit) begin
          // Lowest connected slot wins; stop at once
          out_valid_nxt  = 1'b1;
          out_status_nxt = udst_pkg::ST_CONNECTED;
          out_slot_nxt   = udst_pkg::SLOT_W'(cmp_idx_r);
          out_sock_nxt   = ent.socket;
          state_nxt      = S_IDLE;
        end else begin
          if (take_wild) begin
            wild_found_nxt = 1'b1;
            wild_idx_nxt   = cmp_idx_r;
            wild_ent_nxt   = ent;
          end
          if (at_last) begin
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
            if (wild_found_r || take_wild) begin
              // Bind the wildcard session to the sender
              ram_we                = 1'b1;
              ram_waddr             = bind_idx;
              ram_wdata             = bind_ent;
              ram_wdata.remote_ip   = cur_r.peer_ip;
              ram_wdata.remote_port = cur_r.peer_port;
              out_status_nxt        = udst_pkg::ST_WILDCARD;
              out_slot_nxt          = udst_pkg::SLOT_W'(bind_idx);
              out_sock_nxt          = bind_ent.socket;
            end else begin
              out_status_nxt = udst_pkg::ST_NOMATCH;
              out_slot_nxt   = '0;
              out_sock_nxt   = '0;
            end
          end else begin
            cmp_idx_nxt = cmp_idx_r + 1'b1;
          end
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      valid_r      <= '0;
      wild_found_r <= 1'b0;
      out_valid_r  <= 1'b0;
      cmp_idx_r    <= '0;
    end else begin
      state_r      <= state_nxt;
      valid_r      <= valid_nxt;
      wild_found_r <= wild_found_nxt;
      out_valid_r  <= out_valid_nxt;
      cmp_idx_r    <= cmp_idx_nxt;
    end
    cur_r        <= cur_nxt;
    wild_idx_r   <= wild_idx_nxt;
    wild_ent_r   <= wild_ent_nxt;
    out_status_r <= out_status_nxt;
    out_slot_r   <= out_slot_nxt;
    out_sock_r   <= out_sock_nxt;
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_hit_slot   = out_slot_r;
  assign out_hit_socket = out_sock_r;

endmodule

// ----- sv/udp_socket_demux_table.sv -----
// Top level of the UDP socket demux table: front end, command queue and lookup back end.
// Depends on udst_pkg, udst_front, udst_back (and udst_ram through udst_back).
//
// Usage: present a request with start high; it is taken on a rising edge where busy is
// low. Every request yields exactly one result, shown for a single cycle with out_valid
// high; the result side has no back-pressure, so sample it whenever out_valid is set.
// Results come back in request order. An open, a close or a rejected request (unknown
// code, or an open or close whose slot is not below MAX_SESSIONS) is handled by the back
// end without a scan. A datagram scans the session RAM one entry per cycle through its
// single read port: it stops at the first connected hit and otherwise reads every entry,
// the table depth being min(MAX_SESSIONS,16) because the slot field is four bits. The
// result is registered. A two-entry command queue sits between the front end and the
// back end, so busy rises only once two requests wait behind the one in progress. After
// reset all sessions are closed; no clearing pass is needed.
module udp_socket_demux_table #(
  parameter int MAX_SESSIONS = udst_pkg::MAX_SESSIONS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic [udst_pkg::REQ_W-1:0]    in_req_type,
  input  logic [udst_pkg::SLOT_W-1:0]   in_slot,
  input  logic [udst_pkg::IP_W-1:0]     in_peer_ip,
  input  logic [udst_pkg::PORT_W-1:0]   in_peer_port,
  input  logic [udst_pkg::PORT_W-1:0]   in_own_port,
  input  logic                          in_own_is_any,
  input  logic [udst_pkg::SOCK_W-1:0]   in_socket_id,
  output logic                          out_valid,
  output logic [udst_pkg::STATUS_W-1:0] out_status,
  output logic [udst_pkg::SLOT_W-1:0]   out_hit_slot,
  output logic [udst_pkg::SOCK_W-1:0]   out_hit_socket
);

  udst_pkg::cmd_t head;
  logic           head_valid;
  logic           pop;

  // Accept and classify; hold up to two commands for the back end
  udst_front #(
    .MAX_SESSIONS (MAX_SESSIONS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_req_type   (in_req_type),
    .in_slot       (in_slot),
    .in_peer_ip    (in_peer_ip),
    .in_peer_port  (in_peer_port),
    .in_own_port   (in_own_port),
    .in_own_is_any (in_own_is_any),
    .in_socket_id  (in_socket_id),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop)
  );

  // Execute: update the table or scan it, then drive one result
  udst_back #(
    .MAX_SESSIONS (MAX_SESSIONS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_status     (out_status),
    .out_hit_slot   (out_hit_slot),
    .out_hit_socket (out_hit_socket)
  );

  // A miss or a rejected request reports neither slot nor socket
  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status == udst_pkg::ST_NOMATCH) |->
      (out_hit_slot == '0 && out_hit_socket == '0))
    else $error("no-match result carries a slot or socket");

  // Table updates never report a socket, and only name a slot inside the table
  a_update_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status == udst_pkg::ST_OPENED || out_status == udst_pkg::ST_CLOSED)) |->
      (out_hit_socket == '0 &&
       {{(32 - udst_pkg::SLOT_W){1'b0}}, out_hit_slot} < 32'(MAX_SESSIONS)))
    else $error("open/close result malformed");

  // The back end pops only from a non-empty queue
  a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("command popped from empty queue");

  // A result needs a command to have been taken earlier
  a_result_cause: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !$past(pop)) |-> (out_status == udst_pkg::ST_CONNECTED ||
      out_status == udst_pkg::ST_WILDCARD || out_status == udst_pkg::ST_NOMATCH))
    else $error("update result without a popped command");

endmodule
